@@ hdl/gpv_pkg.sv @@
`default_nettype none

package gpv_pkg;

    // Field widths
    localparam int COORD_W = 8;
    localparam int SIDE_W  = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Grid geometry
    localparam int                MAX_SIDE_DEFAULT = 64;
    localparam logic [SIDE_W-1:0] SIDE_RESET       = 7'd17;
    localparam logic [SIDE_W-1:0] SIDE_MIN         = 7'd3;

    // Start cell of every path
    localparam logic [COORD_W-1:0] START_ROW = 8'd0;
    localparam logic [COORD_W-1:0] START_COL = 8'd1;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PATH = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_GRID_SIDE = 1'b0;

endpackage

`default_nettype wire

@@ hdl/grid_path_validator.sv @@
// Grid path validator: keeps a MAX_SIDE x MAX_SIDE wall bitmap in one synchronous RAM and
// checks paths streamed in cell by cell. Load transfers (operation 0) write one cell; path
// transfers (operation 1) present one cell, and the one with last set ends the path and
// yields one valid_res transfer. One item is taken per clock while results drain; the RAM
// does one access per in-grid item (a write for a load, a read for a path cell). A result
// passes the read stage and the output register, which holds it until taken. The bitmap is
// not cleared at reset: every cell a path visits must be loaded first. grid_side is written
// over the APB port; the user must write it only while the block is idle (not enforced).
// Its low 7 bits are kept; values below 3 act as 3 and values above MAX_SIDE as MAX_SIDE.
`default_nettype none

module grid_path_validator #(
    parameter int MAX_SIDE = gpv_pkg::MAX_SIDE_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // APB configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gpv_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gpv_pkg::DATA_W-1:0]  pwdata,
    output logic      [gpv_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    // Item input
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic [gpv_pkg::COORD_W-1:0] row,
    input  wire logic [gpv_pkg::COORD_W-1:0] col,
    input  wire logic                        wall,
    input  wire logic                        last,
    // Result output
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             valid_res
);

    import gpv_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]     SIDE_A   = AW'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

    // Configuration
    logic [SIDE_W-1:0] grid_side_reg;
    logic [SIDE_W-1:0] side_eff;
    logic              cfg_wr;

    // Path state kept at the front
    logic [COORD_W-1:0] prev_row_reg;
    logic [COORD_W-1:0] prev_col_reg;
    logic               first_pending_reg;
    logic               geo_ok_reg;

    // Read stage
    logic s1_valid_reg;
    logic s1_last_reg;
    logic s1_inside_reg;
    logic s1_geo_ok_reg;
    logic wall_acc_reg;

    // Output register
    logic out_valid_reg;
    logic valid_res_reg;

    logic               accept;
    logic               is_path;
    logic               row_in;
    logic               col_in;
    logic               in_grid;
    logic [AW-1:0]      cell_addr;
    logic signed [COORD_W:0] dr;
    logic signed [COORD_W:0] dc;
    logic               dr_zero;
    logic               dc_zero;
    logic               dr_unit;
    logic               dc_unit;
    logic               order_ok;
    logic               exit_ok;
    logic               geo_now;
    logic               mem_rdata;
    logic               s1_wall_fail;
    logic               out_free;
    logic               s1_done;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GRID_SIDE);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_GRID_SIDE)
        begin
            prdata = DATA_W'(grid_side_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= SIDE_RESET;
        end
        else if (cfg_wr)
        begin
            grid_side_reg <= pwdata[SIDE_W-1:0];
        end
    end

    // Effective side, clamped to the supported range
    always_comb
    begin
        if (grid_side_reg < SIDE_MIN)
        begin
            side_eff = SIDE_MIN;
        end
        else if (grid_side_reg > SIDE_MAX)
        begin
            side_eff = SIDE_MAX;
        end
        else
        begin
            side_eff = grid_side_reg;
        end
    end

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_done  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_done;
    assign accept   = in_valid && !in_stall;
    assign is_path  = (operation == OP_PATH);

    // Bounds and RAM address
    assign row_in    = !row[COORD_W-1] && ({1'b0, row[SIDE_W-1:0]} < {1'b0, side_eff});
    assign col_in    = !col[COORD_W-1] && ({1'b0, col[SIDE_W-1:0]} < {1'b0, side_eff});
    assign in_grid   = row_in && col_in;
    assign cell_addr = AW'(row[SIDE_W-1:0]) * SIDE_A + AW'(col[SIDE_W-1:0]);

    // Unit step from the previous cell
    assign dr      = $signed({row[COORD_W-1], row})
                   - $signed({prev_row_reg[COORD_W-1], prev_row_reg});
    assign dc      = $signed({col[COORD_W-1], col})
                   - $signed({prev_col_reg[COORD_W-1], prev_col_reg});
    assign dr_zero = (dr == '0);
    assign dc_zero = (dc == '0);
    assign dr_unit = (dr == 9'sd1) || (dr == -9'sd1);
    assign dc_unit = (dc == 9'sd1) || (dc == -9'sd1);

    assign order_ok = first_pending_reg ? ((row == START_ROW) && (col == START_COL))
                                        : ((dr_zero && dc_unit) || (dr_unit && dc_zero));
    assign exit_ok  = (row == {1'b0, side_eff - 7'd1}) && (col == {1'b0, side_eff - 7'd2});
    assign geo_now  = geo_ok_reg && order_ok && in_grid;

    // Cell bitmap
    gpv_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_mem (
        .clk   (clk),
        .we    (accept && !is_path && in_grid),
        .waddr (cell_addr),
        .wdata (wall),
        .re    (accept && is_path && in_grid),
        .raddr (cell_addr),
        .rdata (mem_rdata)
    );

    // Front path state: order, bounds and exit checks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_row_reg      <= '0;
            prev_col_reg      <= '0;
            first_pending_reg <= 1'b1;
            geo_ok_reg        <= 1'b1;
        end
        else if (accept && is_path)
        begin
            prev_row_reg <= row;
            prev_col_reg <= col;
            if (last)
            begin
                first_pending_reg <= 1'b1;
                geo_ok_reg        <= 1'b1;
            end
            else
            begin
                first_pending_reg <= 1'b0;
                geo_ok_reg        <= geo_now;
            end
        end
    end

    // Read stage: path cell waiting for its bitmap bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= is_path;
        end
        else if (s1_done)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_path)
        begin
            s1_last_reg   <= last;
            s1_inside_reg <= in_grid;
            s1_geo_ok_reg <= geo_now && (!last || exit_ok);
        end
    end

    assign s1_wall_fail = s1_inside_reg && mem_rdata;

    // Wall hits of the current path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_acc_reg <= 1'b0;
        end
        else if (s1_done)
        begin
            wall_acc_reg <= s1_last_reg ? 1'b0 : (wall_acc_reg || s1_wall_fail);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_done && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_last_reg)
        begin
            valid_res_reg <= s1_geo_ok_reg && !wall_acc_reg && !s1_wall_fail;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;

    // Checks
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with no path cell in the read stage");

    a_path_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_path) |=> s1_valid_reg)
        else $error("accepted path cell missing from the read stage");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_path && last) |=> (first_pending_reg && geo_ok_reg))
        else $error("path state not restarted after the last cell");

    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_done && s1_last_reg) |=> out_valid_reg)
        else $error("finished path produced no result");

endmodule

`default_nettype wire

@@ hdl/gpv_cell_mem.sv @@
`default_nettype none

module gpv_cell_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);

    logic mem_reg [DEPTH];
    logic rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
